### hdl/aimt_pkg.sv
// shared types and constants for the active interval minimum tracker
package aimt_pkg;

   // default number of segment slots
   localparam int unsigned CAPACITY_DEFAULT = 1024;

   // field widths
   localparam int unsigned OP_W     = 2;
   localparam int unsigned ID_W     = 10;
   localparam int unsigned WEIGHT_W = 32;

   // packed word widths, zero filled to whole bytes
   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned RSP_DATA_W = 48;

   // event kinds
   typedef enum logic [OP_W-1:0] {
      OP_OPEN  = 2'd0,
      OP_QUERY = 2'd1,
      OP_CLOSE = 2'd2
   } op_type;

   // weight reported when no segment is active
   localparam logic [WEIGHT_W-1:0] EMPTY_WEIGHT = '1;

   // sequencer states
   typedef enum logic [4:0] {
      ST_CLEAR   = 5'b00001,
      ST_IDLE    = 5'b00010,
      ST_SCAN    = 5'b00100,
      ST_DRAIN   = 5'b01000,
      ST_PUBLISH = 5'b10000
   } state_type;

endpackage

### hdl/active_interval_min_tracker_top.sv
// top level of the active interval minimum tracker: slot table and scanning sequencer
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tuser: op; tdata: slot_id, weight
//  rsp     | out | rsp_tvalid/tready    | tuser: none_active; tdata: query_tag, min_weight
//
// open and close are each a single write into the slot table
// a query scans the table: its one read port gives one slot a cycle
// to the shared signed compare, then a drain state and a publish state that loads the result
// after reset a clearing pass marks every slot inactive, no word is taken
// the result sits in an output register, so opens and closes go on while it waits;
// a query that finishes while an earlier result is still held waits to be loaded
module active_interval_min_tracker_top #(
   parameter int unsigned CAPACITY = aimt_pkg::CAPACITY_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [aimt_pkg::REQ_DATA_W-1:0]   req_tdata,  // [9:0] slot_id, [41:10] weight
   input  logic [aimt_pkg::OP_W-1:0]         req_tuser,  // [1:0] op
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [aimt_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // [9:0] query_tag, [41:10] min_weight
   output logic                              rsp_tuser   // [0] none_active
);

   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned MW = aimt_pkg::WEIGHT_W + 1;  // valid bit over weight
   localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

   // unpacked request fields
   aimt_pkg::op_type                 req_op;
   logic [aimt_pkg::ID_W-1:0]        req_slot_id;
   logic [aimt_pkg::WEIGHT_W-1:0]    req_weight;
   logic                             req_accept;
   logic                             id_in_range;

   assign req_op      = aimt_pkg::op_type'(req_tuser);
   assign req_slot_id = req_tdata[aimt_pkg::ID_W-1:0];
   assign req_weight  = req_tdata[aimt_pkg::ID_W +: aimt_pkg::WEIGHT_W];
   assign id_in_range = 32'(req_slot_id) < 32'(CAPACITY);

   // sequencer and scan registers
   aimt_pkg::state_type              state_ff, state_in;
   logic [AW-1:0]                    idx_ff, idx_in;
   logic                             rd_valid_ff, rd_valid_in;
   logic                             found_ff, found_in;
   logic signed [aimt_pkg::WEIGHT_W-1:0] best_ff, best_in;
   logic [aimt_pkg::ID_W-1:0]        tag_ff, tag_in;

   // output register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [aimt_pkg::ID_W-1:0]        rsp_tag_ff, rsp_tag_in;
   logic [aimt_pkg::WEIGHT_W-1:0]    rsp_min_ff, rsp_min_in;
   logic                             rsp_none_ff, rsp_none_in;

   // slot table: {valid, weight} per slot, one write and one registered read a cycle
   logic [MW-1:0]                    slot_mem_ff [CAPACITY];
   logic [MW-1:0]                    mem_q_ff;
   logic                             wr_en;
   logic [AW-1:0]                    wr_addr;
   logic [MW-1:0]                    wr_data;

   // shared compare unit
   logic                             q_valid;
   logic signed [aimt_pkg::WEIGHT_W-1:0] q_weight;
   logic                             take_q;
   logic                             publish;

   assign q_valid  = mem_q_ff[MW-1];
   assign q_weight = mem_q_ff[aimt_pkg::WEIGHT_W-1:0];
   assign take_q   = rd_valid_ff && q_valid && (!found_ff || (q_weight < best_ff));

   assign req_tready = (state_ff == aimt_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign publish    = (state_ff == aimt_pkg::ST_PUBLISH) && (!rsp_valid_ff || rsp_tready);

   // table write port: clearing pass, or open / close of a slot in range
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = '0;
      if (state_ff == aimt_pkg::ST_CLEAR) begin
         wr_en = 1'b1;
      end else if (req_accept && id_in_range &&
                   (req_op == aimt_pkg::OP_OPEN || req_op == aimt_pkg::OP_CLOSE)) begin
         wr_en   = 1'b1;
         wr_addr = AW'(req_slot_id);
         // close only clears the valid bit; the weight written with it is never looked at
         wr_data = {(req_op == aimt_pkg::OP_OPEN), req_weight};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
      mem_q_ff <= slot_mem_ff[idx_ff];
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      rd_valid_in = 1'b0;
      found_in    = found_ff;
      best_in     = best_ff;
      tag_in      = tag_ff;

      // compare stage runs whenever a scanned word comes back
      if (take_q) begin
         found_in = 1'b1;
         best_in  = q_weight;
      end

      unique case (state_ff)
         aimt_pkg::ST_CLEAR: begin
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = aimt_pkg::ST_IDLE;
            end else begin
               idx_in = AW'(idx_ff + 1'b1);
            end
         end
         aimt_pkg::ST_IDLE: begin
            if (req_accept && req_op == aimt_pkg::OP_QUERY) begin
               idx_in   = '0;
               found_in = 1'b0;
               tag_in   = req_slot_id;
               state_in = aimt_pkg::ST_SCAN;
            end
         end
         aimt_pkg::ST_SCAN: begin
            rd_valid_in = 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = aimt_pkg::ST_DRAIN;
            end else begin
               idx_in = AW'(idx_ff + 1'b1);
            end
         end
         aimt_pkg::ST_DRAIN: begin
            // last read word is compared in this cycle
            state_in = aimt_pkg::ST_PUBLISH;
         end
         aimt_pkg::ST_PUBLISH: begin
            if (publish) begin
               state_in = aimt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = aimt_pkg::ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_none_in  = rsp_none_ff;
      if (publish) begin
         rsp_valid_in = 1'b1;
         rsp_tag_in   = tag_ff;
         rsp_none_in  = !found_ff;
         rsp_min_in   = found_ff ? best_ff : aimt_pkg::EMPTY_WEIGHT;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aimt_pkg::ST_CLEAR;
         idx_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rd_valid_ff  <= rd_valid_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      tag_ff      <= tag_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_min_ff  <= rsp_min_in;
      rsp_none_ff <= rsp_none_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(aimt_pkg::RSP_DATA_W - aimt_pkg::ID_W - aimt_pkg::WEIGHT_W){1'b0}},
                        rsp_min_ff, rsp_tag_ff};
   assign rsp_tuser  = rsp_none_ff;

   // a query taken in idle starts the scan in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_op == aimt_pkg::OP_QUERY |=> state_ff == aimt_pkg::ST_SCAN)
      else $error("query did not start a scan");

   // scanned words only come back while a scan or its drain is under way
   assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> state_ff == aimt_pkg::ST_SCAN || state_ff == aimt_pkg::ST_DRAIN)
      else $error("read word outside a scan");

   // an empty result carries the all-ones weight
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_none_ff |-> rsp_min_ff == aimt_pkg::EMPTY_WEIGHT)
      else $error("empty result with a weight");

   // a loaded result follows a publish cycle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == aimt_pkg::ST_PUBLISH)
      else $error("result loaded without a finished scan");

endmodule
